FILE: rtl/rvcq_pkg.sv
`timescale 1ns / 1ps
package rvcq_pkg;

  // widths cover the largest supported element count (65536)
  localparam int IDX_MAX_W = 16;
  localparam int CNT_MAX_W = 17;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 10;
  localparam int LEN_W     = 11;
  localparam int CFG_AW    = 3;

  localparam logic [10:0] ARRAY_LENGTH_RESET = 11'd1024;

  // register index (word address bit above the byte offset)
  localparam logic REG_ARRAY_LENGTH = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } rvcq_op_t;

  // one transaction traveling down the cell row
  typedef struct packed {
    logic                        valid;
    rvcq_op_t                    op;
    logic [IDX_MAX_W-1:0]        pos;
    logic signed [VAL_W-1:0]     value;
    logic                        empty;
    logic [IDX_MAX_W-1:0]        start;
    logic [IDX_MAX_W-1:0]        stop;
    logic signed [VAL_W-1:0]     lo;
    logic signed [VAL_W-1:0]     hi;
    logic                        hit;
    logic [IDX_MAX_W-1:0]        first;
    logic [CNT_MAX_W-1:0]        count;
  } rvcq_token_t;

endpackage

FILE: rtl/rvcq_cell.sv
`timescale 1ns / 1ps
module rvcq_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  rvcq_pkg::rvcq_token_t tok_in,
  output rvcq_pkg::rvcq_token_t tok_out
);
  import rvcq_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_INDEX);

  logic signed [VAL_W-1:0] element;
  logic                    write_hit;
  logic                    in_window;
  logic                    match;
  rvcq_token_t             tok_next;

  assign write_hit = tok_in.valid && (tok_in.op == OP_WRITE) && (tok_in.pos == MY_IDX);
  assign in_window = (tok_in.start <= MY_IDX) && (MY_IDX <= tok_in.stop);
  assign match     = tok_in.valid && (tok_in.op == OP_QUERY) && !tok_in.empty && in_window
                     && (element >= tok_in.lo) && (element <= tok_in.hi);

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.count = tok_in.count + 1'b1;
      if (!tok_in.hit) begin
        tok_next.hit   = 1'b1;
        tok_next.first = MY_IDX;
      end
    end
  end

  // element held by this cell
  always_ff @(posedge clk) begin
    if (advance && write_hit) begin
      element <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out.valid <= tok_next.valid;
    end
    if (advance) begin
      tok_out.op    <= tok_next.op;
      tok_out.pos   <= tok_next.pos;
      tok_out.value <= tok_next.value;
      tok_out.empty <= tok_next.empty;
      tok_out.start <= tok_next.start;
      tok_out.stop  <= tok_next.stop;
      tok_out.lo    <= tok_next.lo;
      tok_out.hi    <= tok_next.hi;
      tok_out.hit   <= tok_next.hit;
      tok_out.first <= tok_next.first;
      tok_out.count <= tok_next.count;
    end
  end

endmodule

FILE: rtl/range_value_count_query_unit.sv
`timescale 1ns / 1ps
// a query result passes through one register per cell of the row and then the result
//   register before it shows on m_tvalid; a stalled output holds it back
// throughput: one transaction per cycle while the output is not stalled, writes and queries mixed freely
// the depth of the cell row (one cell per element) sets the latency
// reset: rst (synchronous) empties the row and sets array_length to 1024; elements keep
//   whatever they held and are only defined once written
module range_value_count_query_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // position[9:0], element_value[41:10], range_start[51:42], range_end[61:52],
  // low_value[93:62], high_value[125:94], zero pad[127:126]
  input  logic [127:0] s_tdata,
  // opcode[0]
  input  logic [0:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], first_index[10:1], match_count[21:11], zero pad[23:22]
  output logic [23:0]  m_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rvcq_pkg::*;

  localparam logic [CNT_MAX_W-1:0] MAX_LEN = CNT_MAX_W'(MAX_ELEMENTS);

  // configuration
  logic [LEN_W-1:0] array_length;

  // input field unpacking
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_element_value;
  logic [POS_W-1:0]        in_range_start;
  logic [POS_W-1:0]        in_range_end;
  logic signed [VAL_W-1:0] in_low_value;
  logic signed [VAL_W-1:0] in_high_value;
  rvcq_op_t                in_opcode;

  // window clipping at the head of the row
  logic [CNT_MAX_W-1:0] len_ext;
  logic [CNT_MAX_W-1:0] len_use;
  logic [CNT_MAX_W-1:0] stop_ext;
  logic [CNT_MAX_W-1:0] stop_clip;
  logic                 query_empty;
  logic                 write_ok;

  // whole row moves when the result register can take a new value
  logic advance;

  rvcq_token_t head_tok;
  rvcq_token_t chain [0:MAX_ELEMENTS];
  rvcq_token_t last_tok;

  logic [CNT_MAX_W-1:0] count_ext;

  assign in_position      = s_tdata[9:0];
  assign in_element_value = s_tdata[41:10];
  assign in_range_start   = s_tdata[51:42];
  assign in_range_end     = s_tdata[61:52];
  assign in_low_value     = s_tdata[93:62];
  assign in_high_value    = s_tdata[125:94];
  assign in_opcode        = rvcq_op_t'(s_tuser[0]);

  // apb: pready tied high, register written on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ARRAY_LENGTH) ? 32'(array_length) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= ARRAY_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ARRAY_LENGTH)) begin
      array_length <= pwdata[LEN_W-1:0];
    end
  end

  // lengths above the row depth act as the row depth
  assign len_ext     = CNT_MAX_W'(array_length);
  assign len_use     = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
  assign stop_ext    = CNT_MAX_W'(in_range_end);
  assign stop_clip   = ((len_use != '0) && (stop_ext > len_use - 1'b1)) ? len_use - 1'b1
                                                                        : stop_ext;
  assign query_empty = (len_use == '0) || (CNT_MAX_W'(in_range_start) > stop_clip);
  // writes at or beyond the length are dropped at the entry
  assign write_ok    = CNT_MAX_W'(in_position) < len_use;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // token entering cell 0
  always_comb begin
    head_tok.valid = s_tvalid && ((in_opcode == OP_QUERY) || write_ok);
    head_tok.op    = in_opcode;
    head_tok.pos   = IDX_MAX_W'(in_position);
    head_tok.value = in_element_value;
    head_tok.empty = query_empty;
    head_tok.start = IDX_MAX_W'(in_range_start);
    head_tok.stop  = stop_clip[IDX_MAX_W-1:0];
    head_tok.lo    = in_low_value;
    head_tok.hi    = in_high_value;
    head_tok.hit   = 1'b0;
    head_tok.first = '0;
    head_tok.count = '0;
  end

  assign chain[0] = head_tok;

  // one cell per element; writes land in their cell, queries gather count and first hit
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    rvcq_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .advance(advance),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  assign last_tok  = chain[MAX_ELEMENTS];
  assign count_ext = last_tok.count;

  // result register; write transactions leave the row silently
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= last_tok.valid && (last_tok.op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata[0]     <= last_tok.hit;
      m_tdata[10:1]  <= last_tok.first[POS_W-1:0];
      m_tdata[21:11] <= count_ext[LEN_W-1:0];
      m_tdata[23:22] <= 2'b00;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rvcq_pkg::*;

  // row depth plus margin: a write still traveling gives no result, so let it drain
  localparam int ROW_FLUSH   = 1100;
  // receiver hold-off used to back the row up until it stalls its input
  localparam int HOLD_CYCLES = 2500;
  localparam int RAMP_BIAS   = 512;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [2:0] LEN_ADDR = {REG_ARRAY_LENGTH, 2'b00};

  // one input transaction, all fields, writes and queries alike
  typedef struct packed {
    rvcq_op_t            op;
    logic [9:0]          pos;
    logic signed [31:0]  value;
    logic [9:0]          start;
    logic [9:0]          stop;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
  } stream_item_t;

  // one query answer, found in the lowest bit as on m_tdata
  typedef struct packed {
    logic [10:0] match_count;
    logic [9:0]  first_index;
    logic        found;
  } window_answer_t;

  typedef struct {
    stream_item_t   item;
    bit             typed;
    window_answer_t want;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // position[9:0], element_value[41:10], range_start[51:42], range_end[61:52],
  // low_value[93:62], high_value[125:94], zero pad[127:126]
  logic [127:0] s_tdata = '0;
  // opcode[0]
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // found[0], first_index[10:1], match_count[21:11], zero pad[23:22]
  logic [23:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  range_value_count_query_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the element array and of array_length
  logic signed [31:0] element_mirror [1024];
  logic [10:0]        mirror_len = ARRAY_LENGTH_RESET;

  // answers owed by the block, oldest first
  window_answer_t awaited_answers [$];
  int mismatches = 0;
  int answers_seen = 0;

  // idle percentages: sender used by the stimulus, receiver by its own process
  int tx_idle_pct = 21;
  int rx_idle_pct = 80;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  directed_row_t directed_rows [$];

  function automatic int unsigned used_len();
    return (mirror_len > 11'd1024) ? 1024 : int'(mirror_len);
  endfunction

  // count matches in the clipped index window and the value window
  function automatic window_answer_t count_window(input stream_item_t q);
    window_answer_t a;
    int unsigned eff;
    int unsigned top;
    a = '0;
    eff = used_len();
    if (eff == 0) return a;
    top = (32'(q.stop) > eff - 1) ? eff - 1 : 32'(q.stop);
    for (int unsigned i = 32'(q.start); i <= top; i++) begin
      if (element_mirror[i] >= q.lo && element_mirror[i] <= q.hi) begin
        if (!a.found) begin
          a.found = 1'b1;
          a.first_index = 10'(i);
        end
        a.match_count = a.match_count + 11'd1;
      end
    end
    return a;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: return $urandom;
      default: return int'($urandom_range(16)) - 8;
    endcase
  endfunction

  function automatic void add_row(input rvcq_op_t op, input int pos, input logic signed [31:0] val,
                                  input int start, input int stop,
                                  input logic signed [31:0] lo, input logic signed [31:0] hi,
                                  input bit typed, input bit found, input int first,
                                  input int cnt);
    directed_row_t r;
    r.item = '{op: op, pos: 10'(pos), value: val, start: 10'(start), stop: 10'(stop),
               lo: lo, hi: hi};
    r.typed = typed;
    r.want = '{match_count: 11'(cnt), first_index: 10'(first), found: found};
    directed_rows.push_back(r);
  endfunction

  // offer one transaction, wait for the handshake, then book what it causes
  task automatic send_item(input stream_item_t it, input bit typed = 1'b0,
                           input window_answer_t want = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.hi, it.lo, it.stop, it.start, it.value, it.pos};
    s_tuser  <= it.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.op == OP_WRITE) begin
      // writes at or past the used length are dropped
      if (32'(it.pos) < used_len()) element_mirror[it.pos] = it.value;
    end else begin
      awaited_answers.push_back(typed ? want : count_window(it));
    end
  endtask

  // reprogram array_length once the row is empty, then read it back
  task automatic set_array_length(input logic [31:0] v);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (ROW_FLUSH) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LEN_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register taken at this edge
    mirror_len = v[10:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {21'b0, v[10:0]}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("array_length readback: expected %0d got %0d", v[10:0], prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls, plus a long hold-off when the stimulus asks
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result transaction with the oldest awaited answer
  always @(posedge clk) begin
    window_answer_t got;
    window_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[21:0];
      answers_seen++;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: no query outstanding, got found=%0d first=%0d count=%0d",
                   answers_seen, got.found, got.first_index, got.match_count);
      end else begin
        want = awaited_answers.pop_front();
        if (got.found !== want.found || got.first_index !== want.first_index ||
            got.match_count !== want.match_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected found=%0d first=%0d count=%0d, got found=%0d first=%0d count=%0d",
                     answers_seen, want.found, want.first_index, want.match_count,
                     got.found, got.first_index, got.match_count);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_len [8];
    int          phase_items [8];
    int          rnd_idx;
    int unsigned eff;
    int unsigned a;
    int unsigned b;
    logic signed [31:0] va;
    logic signed [31:0] vb;
    stream_item_t it;

    foreach (element_mirror[i]) element_mirror[i] = '0;
    // reset length first, then the extremes of the register and a few in between
    phase_len   = '{1024, 1, 2, 1023, 0, 2047, $urandom_range(3, 1022), 1024};
    phase_items = '{100, 100, 100, 100, 100, 100, 100, 205};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // define every element before anything reads it: element i holds i - 512
    for (int i = 0; i < 1024; i++) begin
      it = '{op: OP_WRITE, pos: 10'(i), value: i - RAMP_BIAS, default: '0};
      send_item(it);
    end

    // directed part, array_length at its reset value of 1024
    add_row(OP_WRITE, 0, VAL_MIN, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_WRITE, 1023, VAL_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_WRITE, 513, -1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_WRITE, 700, 32'sh5A5A_A5A5, 0, 0, 0, 0, 0, 0, 0, 0);
    // whole array, whole value range: every element counts
    add_row(OP_QUERY, 0, 0, 0, 1023, VAL_MIN, VAL_MAX, 1, 1, 0, 1024);
    add_row(OP_QUERY, 0, 0, 0, 1023, VAL_MIN, VAL_MIN, 1, 1, 0, 1);
    add_row(OP_QUERY, 0, 0, 0, 1023, VAL_MAX, VAL_MAX, 1, 1, 1023, 1);
    // empty value window
    add_row(OP_QUERY, 0, 0, 0, 1023, 1, 0, 1, 0, 0, 0);
    // empty index window
    add_row(OP_QUERY, 0, 0, 1023, 0, VAL_MIN, VAL_MAX, 1, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 1023, 1023, VAL_MIN, VAL_MAX, 1, 1, 1023, 1);
    add_row(OP_QUERY, 0, 0, 0, 0, VAL_MIN, VAL_MAX, 1, 1, 0, 1);
    add_row(OP_QUERY, 0, 0, 300, 300, -212, -212, 1, 1, 300, 1);
    // both windows empty at once
    add_row(OP_QUERY, 0, 0, 600, 400, VAL_MAX, VAL_MIN, 1, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, 1023, -1, -1, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 10, 20, -600, -495, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 512, 1023, 0, VAL_MAX, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 1, 1022, VAL_MIN + 1, VAL_MAX - 1, 0, 0, 0, 0);
    add_row(OP_WRITE, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 1000, 1023, 0, 0, 0, 0, 0, 0);
    add_row(OP_WRITE, 0, VAL_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY, 0, 0, 0, 5, VAL_MAX, VAL_MAX, 0, 0, 0, 0);
    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    // random part, one block of transactions per array_length setting
    rnd_idx = 0;
    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        s_tvalid <= 1'b0;
        set_array_length(phase_len[p]);
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        // sender busy / receiver slow, then the reverse, then no idling at all
        if (rnd_idx < 350) begin
          tx_idle_pct = 21;
          rx_idle_pct <= 80;
        end else if (rnd_idx < 700) begin
          tx_idle_pct = 80;
          rx_idle_pct <= 21;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
        // stall the result side long enough for the row to fill and back up
        if (p == 7 && n == 10) hold_req <= hold_req + 1;
        eff = used_len();
        // unused fields carry junk
        it.pos   = 10'($urandom);
        it.value = $urandom;
        it.start = 10'($urandom);
        it.stop  = 10'($urandom);
        it.lo    = $urandom;
        it.hi    = $urandom;
        if ($urandom_range(1) == 0) begin
          it.op = OP_WRITE;
          if (eff != 0 && $urandom_range(99) < 85) it.pos = 10'($urandom_range(eff - 1));
          it.value = rand_value();
        end else begin
          it.op = OP_QUERY;
          // index window: mostly ordered inside the used length, else anything
          if (eff != 0 && $urandom_range(9) < 6) begin
            a = $urandom_range(eff - 1);
            b = $urandom_range(eff - 1);
            it.start = 10'((a < b) ? a : b);
            it.stop  = 10'((a < b) ? b : a);
          end
          // value window: narrow around zero, full, single value, unordered, empty
          va = rand_value();
          vb = rand_value();
          case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
              va = int'($urandom_range(16)) - 8;
              vb = int'($urandom_range(16)) - 8;
              it.lo = (va < vb) ? va : vb;
              it.hi = (va < vb) ? vb : va;
            end
            5: begin
              it.lo = VAL_MIN;
              it.hi = VAL_MAX;
            end
            6: begin
              it.lo = va;
              it.hi = va;
            end
            7, 8: begin
              it.lo = va;
              it.hi = vb;
            end
            default: begin
              it.lo = va;
              it.hi = va - 1;
            end
          endcase
        end
        send_item(it);
        rnd_idx++;
      end
    end
    s_tvalid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (ROW_FLUSH) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
